>>> design/sd_host_command_sequencer_core_macros.svh
// assertion macros shared by the sequencer modules
// every use needs clk and rst_n in scope
`ifndef SD_HOST_COMMAND_SEQUENCER_CORE_MACROS_SVH
`define SD_HOST_COMMAND_SEQUENCER_CORE_MACROS_SVH

// property checked on every rising edge outside reset
`define SDHCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen outside reset
`define SDHCS_NEVER(label, expr, msg) `SDHCS_ASSERT(label, !(expr), msg)

`endif

>>> design/sdhcs_pkg.sv
`default_nettype none

package sdhcs_pkg;

    // input word modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_STATUS = 2'd1;
    localparam logic [1:0] MODE_DMA    = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    // status flag bit positions
    localparam int FL_CRC     = 0;
    localparam int FL_CTO     = 1;
    localparam int FL_REND    = 2;
    localparam int FL_RXOVR   = 3;
    localparam int FL_DCRC    = 4;
    localparam int FL_DTO     = 5;
    localparam int FL_STBIT   = 6;
    localparam int FL_DMAERR  = 7;
    localparam int FL_DMADONE = 8;

    // response types of a start word
    localparam logic [2:0] RT_NONE  = 3'd0;
    localparam logic [2:0] RT_SHORT = 3'd1;
    localparam logic [2:0] RT_R3    = 3'd2;
    localparam logic [2:0] RT_R1    = 3'd3;
    localparam logic [2:0] RT_LONG  = 3'd4;

    // response kind towards the controller
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_LONG  = 2'd2;

    // data direction
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_READ  = 2'd1;
    localparam logic [1:0] DIR_WRITE = 2'd2;

    // result codes
    localparam logic [3:0] RC_OK          = 4'd0;
    localparam logic [3:0] RC_CMDCRC      = 4'd1;
    localparam logic [3:0] RC_CMDTIMEOUT  = 4'd2;
    localparam logic [3:0] RC_MISMATCH    = 4'd3;
    localparam logic [3:0] RC_CARDSTATUS  = 4'd4;
    localparam logic [3:0] RC_UNKNOWN     = 4'd5;
    localparam logic [3:0] RC_RXOVERRUN   = 4'd6;
    localparam logic [3:0] RC_DATACRC     = 4'd7;
    localparam logic [3:0] RC_DATATIMEOUT = 4'd8;
    localparam logic [3:0] RC_STARTBIT    = 4'd9;
    localparam logic [3:0] RC_DMA         = 4'd10;
    localparam logic [3:0] RC_SYSTIMEOUT  = 4'd11;

    // application command prefix
    localparam logic [5:0] PREFIX_INDEX = 6'd55;

    // register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_CARD_ERROR_MASK = 2'd0;
    localparam logic [1:0] REG_COMMAND_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_READ_TIMEOUT    = 2'd2;
    localparam logic [1:0] REG_WRITE_TIMEOUT   = 2'd3;

    localparam logic [31:0] CARD_ERROR_MASK_RST = 32'hFE00_E008;
    localparam logic [23:0] COMMAND_TIMEOUT_RST = 24'd10000;
    localparam logic [23:0] READ_TIMEOUT_RST    = 24'd1000000;
    localparam logic [23:0] WRITE_TIMEOUT_RST   = 24'd1000;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_PREFIX = 5'b00010,
        PH_CMD    = 5'b00100,
        PH_READ   = 5'b01000,
        PH_WRITE  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [31:0] card_error_mask;
        logic [23:0] command_timeout;
        logic [23:0] read_timeout;
        logic [23:0] write_timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  cmd_index;
        logic        app_prefix;
        logic [31:0] argument;
        logic [15:0] card_address;
        logic [2:0]  response_type;
        logic [1:0]  data_type;
        logic [7:0]  retries;
        logic [8:0]  status_flags;
        logic [5:0]  reply_index;
        logic [31:0] reply_word;
    } item_t;

    typedef struct packed {
        logic        issue_valid;
        logic [5:0]  issue_index;
        logic [31:0] issue_argument;
        logic [1:0]  issue_response_kind;
        logic [1:0]  data_direction;
        logic        done_res;
        logic [3:0]  result_code;
        logic [31:0] response_word;
    } result_t;

    function automatic logic [1:0] kind_of(input logic [2:0] rt);
        logic [1:0] k;
        k = KIND_NONE;
        if (rt inside {RT_SHORT, RT_R3, RT_R1}) begin
            k = KIND_SHORT;
        end
        else if (rt == RT_LONG) begin
            k = KIND_LONG;
        end
        return k;
    endfunction

    // unknown data type is handled as no data
    function automatic logic [1:0] data_kind(input logic [1:0] dt);
        logic [1:0] d;
        d = DIR_NONE;
        if (dt inside {DIR_READ, DIR_WRITE}) begin
            d = dt;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> design/sdhcs_cfg_regs.sv
`default_nettype none

module sdhcs_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sdhcs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output sdhcs_pkg::cfg_t                   cfg
);
    import sdhcs_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_CARD_ERROR_MASK: cfg_next.card_error_mask = pwdata;
                REG_COMMAND_TIMEOUT: cfg_next.command_timeout = pwdata[23:0];
                REG_READ_TIMEOUT:    cfg_next.read_timeout    = pwdata[23:0];
                REG_WRITE_TIMEOUT:   cfg_next.write_timeout   = pwdata[23:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.card_error_mask <= CARD_ERROR_MASK_RST;
            cfg_reg.command_timeout <= COMMAND_TIMEOUT_RST;
            cfg_reg.read_timeout    <= READ_TIMEOUT_RST;
            cfg_reg.write_timeout   <= WRITE_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CARD_ERROR_MASK: prdata = cfg_reg.card_error_mask;
            REG_COMMAND_TIMEOUT: prdata = {8'd0, cfg_reg.command_timeout};
            REG_READ_TIMEOUT:    prdata = {8'd0, cfg_reg.read_timeout};
            REG_WRITE_TIMEOUT:   prdata = {8'd0, cfg_reg.write_timeout};
            default:             prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> design/sdhcs_engine.sv
`default_nettype none

`include "sd_host_command_sequencer_core_macros.svh"

module sdhcs_engine (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    input  wire sdhcs_pkg::item_t     item,
    input  wire sdhcs_pkg::cfg_t      cfg,
    input  wire logic                 out_space,
    output logic                      advance,
    output logic                      res_load,
    output sdhcs_pkg::result_t        res
);
    import sdhcs_pkg::*;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ISSUE_FIRST,
        ACT_ISSUE_MAIN,
        ACT_FAIL,
        ACT_RETRY,
        ACT_DONE,
        ACT_ENTER_READ,
        ACT_ENTER_WRITE,
        ACT_TICK
    } act_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  retries_left_reg, retries_left_next;
    logic [5:0]  saved_index_reg, saved_index_next;
    logic        saved_prefix_reg, saved_prefix_next;
    logic [31:0] saved_argument_reg, saved_argument_next;
    logic [15:0] saved_card_address_reg, saved_card_address_next;
    logic [2:0]  saved_rt_reg, saved_rt_next;
    logic [1:0]  saved_dt_reg, saved_dt_next;
    logic [23:0] ticks_left_reg, ticks_left_next;
    logic [31:0] captured_reg, captured_next;

    act_t        act;
    logic        res_fire;
    logic        cmd_phase;
    logic [2:0]  chk_rt;
    logic [5:0]  want_index;
    logic [1:0]  dk;
    logic [3:0]  code;
    logic        use_new;
    logic        src_prefix;
    logic [5:0]  src_index;
    logic [31:0] src_argument;
    logic [15:0] src_card_address;
    logic [2:0]  src_rt;
    logic [1:0]  src_dt;

    always_comb
    begin
        cmd_phase  = (phase_reg == PH_PREFIX) || (phase_reg == PH_CMD);
        chk_rt     = (phase_reg == PH_PREFIX) ? RT_R1 : saved_rt_reg;
        want_index = (phase_reg == PH_PREFIX) ? PREFIX_INDEX : saved_index_reg;
        dk         = data_kind(saved_dt_reg);
        captured_next = captured_reg;
        code = RC_OK;
        act  = ACT_NONE;

        // decide what this word does
        case (item.mode)
            MODE_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    act = ACT_ISSUE_FIRST;
                    captured_next = '0;
                end
            end
            MODE_STATUS:
            begin
                if (cmd_phase)
                begin
                    if (chk_rt inside {RT_SHORT, RT_R1, RT_LONG})
                    begin
                        if (item.status_flags[FL_CRC]) code = RC_CMDCRC;
                        if (item.status_flags[FL_CTO]) code = RC_CMDTIMEOUT;
                        if (item.status_flags[FL_REND])
                        begin
                            if ((chk_rt == RT_R1) && (item.reply_index != want_index))
                            begin
                                code = RC_MISMATCH;
                            end
                            captured_next = item.reply_word;
                            if ((chk_rt == RT_R1) &&
                                ((item.reply_word & cfg.card_error_mask) != '0))
                            begin
                                code = RC_CARDSTATUS;
                            end
                        end
                    end
                    else if (chk_rt == RT_R3)
                    begin
                        if (item.status_flags[FL_CTO]) code = RC_CMDTIMEOUT;
                        if (item.status_flags[FL_REND] || item.status_flags[FL_CRC])
                        begin
                            captured_next = item.reply_word;
                        end
                    end
                    if (code != RC_OK)             act = ACT_FAIL;
                    else if (phase_reg == PH_PREFIX) act = ACT_ISSUE_MAIN;
                    else if (dk == DIR_READ)       act = ACT_ENTER_READ;
                    else if (dk == DIR_WRITE)      act = ACT_ENTER_WRITE;
                    else                           act = ACT_DONE;
                end
                else if (phase_reg != PH_IDLE)
                begin
                    // data phase, no flag means unknown
                    code = RC_UNKNOWN;
                    if (item.status_flags[FL_RXOVR]) code = RC_RXOVERRUN;
                    if (item.status_flags[FL_DCRC])  code = RC_DATACRC;
                    if (item.status_flags[FL_DTO])   code = RC_DATATIMEOUT;
                    if (item.status_flags[FL_STBIT]) code = RC_STARTBIT;
                    act = ACT_DONE;
                end
            end
            MODE_DMA:
            begin
                if ((phase_reg inside {PH_CMD, PH_READ, PH_WRITE}) && (dk != DIR_NONE))
                begin
                    if (item.status_flags[FL_DMAERR])
                    begin
                        code = RC_DMA;
                        act  = ACT_FAIL;
                    end
                    else if (item.status_flags[FL_DMADONE])
                    begin
                        act = ACT_DONE;
                    end
                end
            end
            MODE_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (ticks_left_reg > 24'd1)
                    begin
                        act = ACT_TICK;
                    end
                    else
                    begin
                        code = RC_SYSTIMEOUT;
                        act  = ACT_FAIL;
                    end
                end
            end
            default:
            begin
                act = ACT_NONE;
            end
        endcase

        // a failure retries while budget remains
        if (act == ACT_FAIL)
        begin
            act = (retries_left_reg != '0) ? ACT_RETRY : ACT_DONE;
        end

        use_new          = (act == ACT_ISSUE_FIRST);
        src_prefix       = use_new ? item.app_prefix    : saved_prefix_reg;
        src_index        = use_new ? item.cmd_index     : saved_index_reg;
        src_argument     = use_new ? item.argument      : saved_argument_reg;
        src_card_address = use_new ? item.card_address  : saved_card_address_reg;
        src_rt           = use_new ? item.response_type : saved_rt_reg;
        src_dt           = use_new ? item.data_type     : saved_dt_reg;

        phase_next              = phase_reg;
        retries_left_next       = retries_left_reg;
        saved_index_next        = saved_index_reg;
        saved_prefix_next       = saved_prefix_reg;
        saved_argument_next     = saved_argument_reg;
        saved_card_address_next = saved_card_address_reg;
        saved_rt_next           = saved_rt_reg;
        saved_dt_next           = saved_dt_reg;
        ticks_left_next         = ticks_left_reg;
        res      = '0;
        res_fire = 1'b0;

        case (act)
            ACT_ISSUE_FIRST, ACT_RETRY:
            begin
                if (use_new)
                begin
                    saved_index_next        = item.cmd_index;
                    saved_prefix_next       = item.app_prefix;
                    saved_argument_next     = item.argument;
                    saved_card_address_next = item.card_address;
                    saved_rt_next           = item.response_type;
                    saved_dt_next           = item.data_type;
                    retries_left_next       = item.retries;
                end
                else
                begin
                    retries_left_next = retries_left_reg - 8'd1;
                end
                res_fire        = 1'b1;
                res.issue_valid = 1'b1;
                ticks_left_next = cfg.command_timeout;
                if (src_prefix)
                begin
                    phase_next              = PH_PREFIX;
                    res.issue_index         = PREFIX_INDEX;
                    res.issue_argument      = {src_card_address, 16'd0};
                    res.issue_response_kind = KIND_SHORT;
                    res.data_direction      = DIR_NONE;
                end
                else
                begin
                    phase_next              = PH_CMD;
                    res.issue_index         = src_index;
                    res.issue_argument      = src_argument;
                    res.issue_response_kind = kind_of(src_rt);
                    res.data_direction      = data_kind(src_dt);
                end
            end
            ACT_ISSUE_MAIN:
            begin
                res_fire                = 1'b1;
                phase_next              = PH_CMD;
                ticks_left_next         = cfg.command_timeout;
                res.issue_valid         = 1'b1;
                res.issue_index         = saved_index_reg;
                res.issue_argument      = saved_argument_reg;
                res.issue_response_kind = kind_of(saved_rt_reg);
                res.data_direction      = dk;
            end
            ACT_DONE:
            begin
                res_fire          = 1'b1;
                phase_next        = PH_IDLE;
                ticks_left_next   = '0;
                res.done_res      = 1'b1;
                res.result_code   = code;
                res.response_word = captured_next;
            end
            ACT_ENTER_READ:
            begin
                phase_next      = PH_READ;
                ticks_left_next = cfg.read_timeout;
            end
            ACT_ENTER_WRITE:
            begin
                phase_next      = PH_WRITE;
                ticks_left_next = cfg.write_timeout;
            end
            ACT_TICK:
            begin
                ticks_left_next = ticks_left_reg - 24'd1;
            end
            default:
            begin
                res_fire = 1'b0;
            end
        endcase
    end

    assign advance  = item_valid && (!res_fire || out_space);
    assign res_load = advance && res_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            ticks_left_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            ticks_left_reg <= ticks_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            retries_left_reg       <= retries_left_next;
            saved_index_reg        <= saved_index_next;
            saved_prefix_reg       <= saved_prefix_next;
            saved_argument_reg     <= saved_argument_next;
            saved_card_address_reg <= saved_card_address_next;
            saved_rt_reg           <= saved_rt_next;
            saved_dt_reg           <= saved_dt_next;
            captured_reg           <= captured_next;
        end
    end

    `SDHCS_ASSERT(a_idle_no_ticks, (phase_reg == PH_IDLE) |-> (ticks_left_reg == '0), "ticks left while idle")
    `SDHCS_ASSERT(a_done_to_idle, (res_load && res.done_res) |=> (phase_reg == PH_IDLE), "done word did not return to idle")
    `SDHCS_ASSERT(a_issue_loads_timer, (res_load && res.issue_valid) |=> (ticks_left_reg == $past(cfg.command_timeout)), "issue did not load command timer")
    `SDHCS_NEVER(a_fire_needs_space, res_load && !out_space, "result loaded into full output register")

endmodule

`default_nettype wire

>>> design/sdhcs_out_reg.sv
`default_nettype none

module sdhcs_out_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire sdhcs_pkg::result_t res,
    input  wire logic          out_stall,
    output logic               out_space,
    output logic               out_valid,
    output sdhcs_pkg::result_t res_out
);
    import sdhcs_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t res_reg;

    assign out_space = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

>>> design/sd_host_command_sequencer_core.sv
// sd host command sequencer, one command at a time
// input channel (in_valid / in_stall) carries one word per event: start,
// controller status, dma event or timer tick, selected by mode
// output channel (out_valid / out_stall) carries an issue word (send this
// command now) or a done word (command finished, result_code and
// response_word); many input words give no output word at all
// apb port holds card_error_mask and the three timeout tick counts at byte
// addresses 0, 4, 8 and 12; write them only while no command is running
// latency: a word accepted at one edge is decided at the next, its output
// word is valid right after that edge (one cycle accept to output valid)
// throughput: one word per cycle, set by the single decision stage between
// the input register and the output register
// when the receiver stalls the output word holds; one more input word is
// still taken into the input register, after which in_stall rises until
// the output register frees up; words that give no output never wait
// reset: idle phase, no command in flight, registers at their defaults,
// both channel registers empty
`default_nettype none

`include "sd_host_command_sequencer_core_macros.svh"

module sd_host_command_sequencer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [5:0]  cmd_index,
    input  wire logic        app_prefix,
    input  wire logic [31:0] argument,
    input  wire logic [15:0] card_address,
    input  wire logic [2:0]  response_type,
    input  wire logic [1:0]  data_type,
    input  wire logic [7:0]  retries,
    input  wire logic [8:0]  status_flags,
    input  wire logic [5:0]  reply_index,
    input  wire logic [31:0] reply_word,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             issue_valid,
    output logic      [5:0]  issue_index,
    output logic      [31:0] issue_argument,
    output logic      [1:0]  issue_response_kind,
    output logic      [1:0]  data_direction,
    output logic             done_res,
    output logic      [3:0]  result_code,
    output logic      [31:0] response_word
);
    import sdhcs_pkg::*;

    cfg_t    cfg;
    item_t   item_in;
    item_t   item_reg;
    logic    in_valid_reg, in_valid_next;
    logic    in_accept;
    logic    advance;
    logic    res_load;
    logic    out_space;
    result_t res;
    result_t res_out;

    sdhcs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // gather the input word
    assign item_in = {mode, cmd_index, app_prefix, argument, card_address, response_type,
                      data_type, retries, status_flags, reply_index, reply_word};

    // input register: full and not moving on means stall
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= item_in;
        end
    end

    // decision stage and sequencer state
    sdhcs_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (item_reg),
        .cfg        (cfg),
        .out_space  (out_space),
        .advance    (advance),
        .res_load   (res_load),
        .res        (res)
    );

    // output register
    sdhcs_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .out_stall (out_stall),
        .out_space (out_space),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign issue_valid         = res_out.issue_valid;
    assign issue_index         = res_out.issue_index;
    assign issue_argument      = res_out.issue_argument;
    assign issue_response_kind = res_out.issue_response_kind;
    assign data_direction      = res_out.data_direction;
    assign done_res            = res_out.done_res;
    assign result_code         = res_out.result_code;
    assign response_word       = res_out.response_word;

    // a waiting input word must not be overwritten
    `SDHCS_ASSERT(a_held_word_stable, (in_valid_reg && !advance) |=> $stable(item_reg), "waiting input word changed")

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;
    import sdhcs_pkg::*;

    // generous bound on the whole run
    localparam int CYCLE_LIMIT = 400000;

    // status flag masks built from the package bit positions
    localparam logic [8:0] F_CRC     = 9'b1 << FL_CRC;
    localparam logic [8:0] F_CTO     = 9'b1 << FL_CTO;
    localparam logic [8:0] F_REND    = 9'b1 << FL_REND;
    localparam logic [8:0] F_RXOVR   = 9'b1 << FL_RXOVR;
    localparam logic [8:0] F_DCRC    = 9'b1 << FL_DCRC;
    localparam logic [8:0] F_DTO     = 9'b1 << FL_DTO;
    localparam logic [8:0] F_STBIT   = 9'b1 << FL_STBIT;
    localparam logic [8:0] F_DMAERR  = 9'b1 << FL_DMAERR;
    localparam logic [8:0] F_DMADONE = 9'b1 << FL_DMADONE;

    // one line of the directed plan: a register write or an event word,
    // the latter with its output word typed in where it is obvious
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_index;
        logic [31:0] value;
        item_t       w;
        bit          typed;
        result_t     res;
    } plan_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        in_valid = 1'b0;
    wire         in_stall;
    item_t       in_word = '0;
    wire         out_valid;
    logic        out_stall = 1'b0;
    wire         issue_valid;
    wire  [5:0]  issue_index;
    wire  [31:0] issue_argument;
    wire  [1:0]  issue_response_kind;
    wire  [1:0]  data_direction;
    wire         done_res;
    wire  [3:0]  result_code;
    wire  [31:0] response_word;

    // shadow of the register file, tracked by apb writes
    logic [31:0] mask_cfg   = CARD_ERROR_MASK_RST;
    logic [23:0] cmd_to_cfg = COMMAND_TIMEOUT_RST;
    logic [23:0] rd_to_cfg  = READ_TIMEOUT_RST;
    logic [23:0] wr_to_cfg  = WRITE_TIMEOUT_RST;

    // sequencer state as the testbench sees it
    phase_t      cur_phase = PH_IDLE;
    logic [7:0]  retries_left = '0;
    logic [5:0]  cur_index = '0;
    logic        cur_prefix = 1'b0;
    logic [31:0] cur_argument = '0;
    logic [15:0] cur_card_address = '0;
    logic [2:0]  cur_rtype = '0;
    logic [1:0]  cur_dtype = '0;
    logic [23:0] ticks_left = '0;
    logic [31:0] captured_word = '0;

    // output words still owed by the sequencer, oldest first
    result_t     due_words[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // sender pacing
    bit          offering = 1'b0;
    int          burst_left = 0;

    // receiver stall pattern and the one long hold-off
    bit          hold_off_request = 1'b0;
    int          hold_left = 0;
    int          seg_left = 0;
    int          stall_pct = 0;

    result_t     seen_word;
    result_t     wanted_word;
    plan_row_t   directed_plan[$];

    sd_host_command_sequencer_core uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .mode                (in_word.mode),
        .cmd_index           (in_word.cmd_index),
        .app_prefix          (in_word.app_prefix),
        .argument            (in_word.argument),
        .card_address        (in_word.card_address),
        .response_type       (in_word.response_type),
        .data_type           (in_word.data_type),
        .retries             (in_word.retries),
        .status_flags        (in_word.status_flags),
        .reply_index         (in_word.reply_index),
        .reply_word          (in_word.reply_word),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .issue_valid         (issue_valid),
        .issue_index         (issue_index),
        .issue_argument      (issue_argument),
        .issue_response_kind (issue_response_kind),
        .data_direction      (data_direction),
        .done_res            (done_res),
        .result_code         (result_code),
        .response_word       (response_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // word builders
    // ---------------------------------------------------------------

    function automatic result_t issue_word(input logic [5:0] idx, input logic [31:0] arg,
                                          input logic [1:0] kind, input logic [1:0] dir);
        result_t r;
        r = '0;
        r.issue_valid = 1'b1;
        r.issue_index = idx;
        r.issue_argument = arg;
        r.issue_response_kind = kind;
        r.data_direction = dir;
        return r;
    endfunction

    function automatic result_t done_word(input logic [3:0] code, input logic [31:0] resp);
        result_t r;
        r = '0;
        r.done_res = 1'b1;
        r.result_code = code;
        r.response_word = resp;
        return r;
    endfunction

    function automatic item_t start_word(input logic [5:0] idx, input logic pfx,
                                         input logic [31:0] arg, input logic [15:0] rca,
                                         input logic [2:0] rt, input logic [1:0] dt,
                                         input logic [7:0] budget);
        item_t w;
        w = '0;
        w.mode = MODE_START;
        w.cmd_index = idx;
        w.app_prefix = pfx;
        w.argument = arg;
        w.card_address = rca;
        w.response_type = rt;
        w.data_type = dt;
        w.retries = budget;
        return w;
    endfunction

    function automatic item_t event_word(input logic [1:0] m, input logic [8:0] flags,
                                         input logic [5:0] ridx, input logic [31:0] rword);
        item_t w;
        w = '0;
        w.mode = m;
        w.status_flags = flags;
        w.reply_index = ridx;
        w.reply_word = rword;
        return w;
    endfunction

    // ---------------------------------------------------------------
    // sequencer predictor
    // ---------------------------------------------------------------

    // r3 is short on the wire, unknown response types send nothing back
    function automatic logic [1:0] reply_kind(input logic [2:0] rt);
        case (rt)
            RT_SHORT, RT_R3, RT_R1: return KIND_SHORT;
            RT_LONG:                return KIND_LONG;
            default:                return KIND_NONE;
        endcase
    endfunction

    // data type 3 arms nothing
    function automatic logic [1:0] armed_direction();
        if (cur_dtype == DIR_READ || cur_dtype == DIR_WRITE)
        begin
            return cur_dtype;
        end
        return DIR_NONE;
    endfunction

    function automatic result_t finish_command(input logic [3:0] code);
        cur_phase = PH_IDLE;
        ticks_left = '0;
        return done_word(code, captured_word);
    endfunction

    function automatic result_t issue_main_command();
        cur_phase = PH_CMD;
        ticks_left = cmd_to_cfg;
        return issue_word(cur_index, cur_argument, reply_kind(cur_rtype), armed_direction());
    endfunction

    // an application command goes out behind cmd55 carrying the card address
    function automatic result_t issue_from_top();
        if (cur_prefix)
        begin
            cur_phase = PH_PREFIX;
            ticks_left = cmd_to_cfg;
            return issue_word(PREFIX_INDEX, {cur_card_address, 16'h0000}, KIND_SHORT, DIR_NONE);
        end
        return issue_main_command();
    endfunction

    function automatic result_t retry_or_fail(input logic [3:0] code);
        if (retries_left != 0)
        begin
            retries_left--;
            return issue_from_top();
        end
        return finish_command(code);
    endfunction

    // steps the sequencer by one event word; returns 1 when an output word is due,
    // acted is 0 for words the sequencer drops
    function automatic bit sequence_event(input item_t w, output result_t r, output bit acted);
        logic [3:0] code;
        logic [2:0] rt;
        logic [5:0] want;
        r = '0;
        acted = 1'b1;
        code = RC_OK;
        if (w.mode == MODE_START)
        begin
            if (cur_phase != PH_IDLE)
            begin
                acted = 1'b0;
                return 1'b0;
            end
            cur_index = w.cmd_index;
            cur_prefix = w.app_prefix;
            cur_argument = w.argument;
            cur_card_address = w.card_address;
            cur_rtype = w.response_type;
            cur_dtype = w.data_type;
            retries_left = w.retries;
            captured_word = '0;
            r = issue_from_top();
            return 1'b1;
        end
        if (cur_phase == PH_IDLE)
        begin
            acted = 1'b0;
            return 1'b0;
        end
        case (w.mode)
            MODE_STATUS:
            begin
                if (cur_phase == PH_PREFIX || cur_phase == PH_CMD)
                begin
                    rt = (cur_phase == PH_PREFIX) ? RT_R1 : cur_rtype;
                    want = (cur_phase == PH_PREFIX) ? PREFIX_INDEX : cur_index;
                    // later checks override earlier ones
                    if (rt == RT_SHORT || rt == RT_R1 || rt == RT_LONG)
                    begin
                        if (w.status_flags[FL_CRC]) code = RC_CMDCRC;
                        if (w.status_flags[FL_CTO]) code = RC_CMDTIMEOUT;
                        if (w.status_flags[FL_REND])
                        begin
                            if (rt == RT_R1 && w.reply_index != want) code = RC_MISMATCH;
                            captured_word = w.reply_word;
                            if (rt == RT_R1 && (w.reply_word & mask_cfg) != 0)
                                code = RC_CARDSTATUS;
                        end
                    end
                    else if (rt == RT_R3)
                    begin
                        // r3 carries no crc, a crc failure still means a reply came
                        if (w.status_flags[FL_CTO]) code = RC_CMDTIMEOUT;
                        if (w.status_flags[FL_REND] || w.status_flags[FL_CRC])
                            captured_word = w.reply_word;
                    end
                    if (code != RC_OK)
                    begin
                        r = retry_or_fail(code);
                        return 1'b1;
                    end
                    if (cur_phase == PH_PREFIX)
                    begin
                        r = issue_main_command();
                        return 1'b1;
                    end
                    if (armed_direction() == DIR_READ)
                    begin
                        cur_phase = PH_READ;
                        ticks_left = rd_to_cfg;
                        return 1'b0;
                    end
                    if (armed_direction() == DIR_WRITE)
                    begin
                        cur_phase = PH_WRITE;
                        ticks_left = wr_to_cfg;
                        return 1'b0;
                    end
                    r = finish_command(RC_OK);
                    return 1'b1;
                end
                // data phase status is never retried
                code = RC_UNKNOWN;
                if (w.status_flags[FL_RXOVR]) code = RC_RXOVERRUN;
                if (w.status_flags[FL_DCRC])  code = RC_DATACRC;
                if (w.status_flags[FL_DTO])   code = RC_DATATIMEOUT;
                if (w.status_flags[FL_STBIT]) code = RC_STARTBIT;
                r = finish_command(code);
                return 1'b1;
            end
            MODE_DMA:
            begin
                if (cur_phase == PH_PREFIX || armed_direction() == DIR_NONE)
                begin
                    acted = 1'b0;
                    return 1'b0;
                end
                if (w.status_flags[FL_DMAERR])
                begin
                    r = retry_or_fail(RC_DMA);
                    return 1'b1;
                end
                if (w.status_flags[FL_DMADONE])
                begin
                    r = finish_command(RC_OK);
                    return 1'b1;
                end
                acted = 1'b0;
                return 1'b0;
            end
            default:
            begin
                if (ticks_left > 1)
                begin
                    ticks_left--;
                    return 1'b0;
                end
                ticks_left = '0;
                r = retry_or_fail(RC_SYSTIMEOUT);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // random words shaped by where the sequencer stands
    // ---------------------------------------------------------------

    function automatic item_t random_word();
        item_t w;
        int pick;
        w.mode = MODE_STATUS;
        w.cmd_index = 6'($urandom);
        w.app_prefix = 1'($urandom);
        w.argument = $urandom;
        w.card_address = 16'($urandom);
        w.response_type = 3'($urandom);
        w.data_type = 2'($urandom);
        // small budgets mostly, now and then the full range
        w.retries = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        w.status_flags = 9'($urandom);
        w.reply_index = 6'($urandom);
        w.reply_word = $urandom;
        pick = $urandom_range(0, 99);
        if (cur_phase == PH_IDLE)
        begin
            w.mode = (pick < 88) ? MODE_START : 2'($urandom_range(1, 3));
        end
        else if (cur_phase == PH_PREFIX || cur_phase == PH_CMD)
        begin
            if (pick < 6)       w.mode = MODE_START;
            else if (pick < 16) w.mode = MODE_DMA;
            else if (pick < 34) w.mode = MODE_TICK;
            else if (pick < 80)
            begin
                // clean reply: right index, no card status error, data bits as noise
                w.mode = MODE_STATUS;
                w.status_flags = (9'($urandom) & 9'h1F8) | F_REND;
                w.reply_index = (cur_phase == PH_PREFIX) ? PREFIX_INDEX : cur_index;
                w.reply_word = $urandom & ~mask_cfg;
            end
        end
        else
        begin
            if (pick < 5)       w.mode = MODE_START;
            else if (pick < 35)
            begin
                w.mode = MODE_DMA;
                if ($urandom_range(0, 3) != 0) w.status_flags = F_DMADONE;
            end
            else if (pick < 65) w.mode = MODE_TICK;
        end
        return w;
    endfunction

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // offers one word, holds it until taken, then books what it should cause
    task automatic deliver(input item_t w, input bit typed, input result_t typed_res,
                           output bit acted);
        result_t r;
        bit has_res;
        in_word <= w;
        in_valid <= 1'b1;
        offering = 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        has_res = sequence_event(w, r, acted);
        if (typed)
            due_words.push_back(typed_res);
        else if (has_res)
            due_words.push_back(r);
    endtask

    // bursts of random length, gaps of random length between them
    task automatic pace(input bit force_gap);
        if (force_gap || burst_left == 0)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // let every owed word drain, then wait a little for words that give no output
    task automatic settle();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (due_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write: setup cycle, access cycle, register taken at the access edge
    task automatic write_register(input logic [1:0] reg_index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (reg_index)
            REG_CARD_ERROR_MASK: mask_cfg = value;
            REG_COMMAND_TIMEOUT: cmd_to_cfg = value[23:0];
            REG_READ_TIMEOUT:    rd_to_cfg = value[23:0];
            default:             wr_to_cfg = value[23:0];
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] mask, input logic [31:0] cto,
                             input logic [31:0] rto, input logic [31:0] wto);
        write_register(REG_CARD_ERROR_MASK, mask);
        write_register(REG_COMMAND_TIMEOUT, cto);
        write_register(REG_READ_TIMEOUT, rto);
        write_register(REG_WRITE_TIMEOUT, wto);
    endtask

    // random words until enough have done something, then close the open command
    task automatic run_phase(input int target);
        int acted_count;
        bit acted;
        acted_count = 0;
        while (acted_count < target)
        begin
            deliver(random_word(), 1'b0, '0, acted);
            if (acted) acted_count++;
            pace(1'b0);
        end
        // a flagless status moves any phase one step towards idle
        while (cur_phase != PH_IDLE)
        begin
            deliver(event_word(MODE_STATUS, 9'h000, 6'd0, 32'h0), 1'b0, '0, acted);
            pace(1'b0);
        end
        settle();
    endtask

    function automatic void add_row(input item_t w);
        plan_row_t p;
        p = '{default: '0};
        p.w = w;
        directed_plan.push_back(p);
    endfunction

    function automatic void add_typed_row(input item_t w, input result_t res);
        plan_row_t p;
        p = '{default: '0};
        p.w = w;
        p.typed = 1'b1;
        p.res = res;
        directed_plan.push_back(p);
    endfunction

    function automatic void add_cfg_row(input logic [1:0] reg_index, input logic [31:0] value);
        plan_row_t p;
        p = '{default: '0};
        p.is_cfg = 1'b1;
        p.reg_index = reg_index;
        p.value = value;
        directed_plan.push_back(p);
    endfunction

    // ---------------------------------------------------------------
    // receiver side: stall pattern of its own, plus one long hold-off
    // ---------------------------------------------------------------

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                // long hold so that the sequencer fills up and stalls its input
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // output checker: every taken word against the oldest owed one
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            seen_word = {issue_valid, issue_index, issue_argument, issue_response_kind,
                         data_direction, done_res, result_code, response_word};
            if (due_words.size() == 0)
            begin
                $error("output word with nothing owed: %0h", seen_word);
                mismatch_count++;
            end
            else
            begin
                wanted_word = due_words.pop_front();
                check_field("issue_valid", wanted_word.issue_valid, seen_word.issue_valid);
                check_field("issue_index", wanted_word.issue_index, seen_word.issue_index);
                check_field("issue_argument", wanted_word.issue_argument,
                            seen_word.issue_argument);
                check_field("issue_response_kind", wanted_word.issue_response_kind,
                            seen_word.issue_response_kind);
                check_field("data_direction", wanted_word.data_direction,
                            seen_word.data_direction);
                check_field("done_res", wanted_word.done_res, seen_word.done_res);
                check_field("result_code", wanted_word.result_code, seen_word.result_code);
                check_field("response_word", wanted_word.response_word,
                            seen_word.response_word);
            end
        end
    end

    // watchdog on the whole run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sd_host_command_sequencer_core test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        bit acted;

        // events with no command running are dropped
        add_row(event_word(MODE_STATUS, 9'h1FF, 6'h3F, 32'hFFFF_FFFF));
        add_row(event_word(MODE_DMA, 9'h1FF, 6'h3F, 32'hFFFF_FFFF));
        // application command, index, argument and card address at their top values
        add_typed_row(start_word(6'h3F, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, RT_R1, DIR_NONE, 8'd0),
                      issue_word(PREFIX_INDEX, 32'hFFFF_0000, KIND_SHORT, DIR_NONE));
        // a start while busy is ignored
        add_row(start_word(6'd5, 1'b0, 32'h5, 16'h0, RT_SHORT, DIR_READ, 8'd9));
        // prefix answered, main command follows
        add_typed_row(event_word(MODE_STATUS, F_REND, PREFIX_INDEX, 32'h0),
                      issue_word(6'h3F, 32'hFFFF_FFFF, KIND_SHORT, DIR_NONE));
        // wrong echoed index, budget spent
        add_typed_row(event_word(MODE_STATUS, F_REND, 6'd62, 32'h0),
                      done_word(RC_MISMATCH, 32'h0));
        // long response with read data, one retry: crc, then timeout over crc
        add_typed_row(start_word(6'd0, 1'b0, 32'h0, 16'h0, RT_LONG, DIR_READ, 8'd1),
                      issue_word(6'd0, 32'h0, KIND_LONG, DIR_READ));
        add_typed_row(event_word(MODE_STATUS, F_CRC, 6'd0, 32'h0),
                      issue_word(6'd0, 32'h0, KIND_LONG, DIR_READ));
        add_typed_row(event_word(MODE_STATUS, F_CRC | F_CTO, 6'd0, 32'h0),
                      done_word(RC_CMDTIMEOUT, 32'h0));
        // clean r1 reply opens the read phase; flagless status there is unknown
        add_typed_row(start_word(6'd17, 1'b0, 32'h1234_5678, 16'h0, RT_R1, DIR_READ, 8'd0),
                      issue_word(6'd17, 32'h1234_5678, KIND_SHORT, DIR_READ));
        add_row(event_word(MODE_STATUS, F_REND, 6'd17, 32'h0000_0900));
        add_row(event_word(MODE_DMA, 9'h000, 6'd0, 32'h0));
        add_typed_row(event_word(MODE_STATUS, 9'h000, 6'd0, 32'h0),
                      done_word(RC_UNKNOWN, 32'h0000_0900));
        // r3 takes a crc failure as a reply; of the data errors the start bit wins
        add_typed_row(start_word(6'd24, 1'b0, 32'h0000_0018, 16'h0, RT_R3, DIR_WRITE, 8'd0),
                      issue_word(6'd24, 32'h0000_0018, KIND_SHORT, DIR_WRITE));
        add_row(event_word(MODE_STATUS, F_CRC, 6'd0, 32'hCAFE_F00D));
        add_typed_row(event_word(MODE_STATUS, F_RXOVR | F_DCRC | F_DTO | F_STBIT, 6'd0, 32'h0),
                      done_word(RC_STARTBIT, 32'hCAFE_F00D));
        // unknown response and data types, dma ignored without data
        add_typed_row(start_word(6'd25, 1'b0, 32'hA5A5_A5A5, 16'h0, 3'd7, 2'd3, 8'hFF),
                      issue_word(6'd25, 32'hA5A5_A5A5, KIND_NONE, DIR_NONE));
        add_row(event_word(MODE_DMA, F_DMAERR | F_DMADONE, 6'd0, 32'h0));
        add_typed_row(event_word(MODE_STATUS, 9'h000, 6'd0, 32'h0),
                      done_word(RC_OK, 32'h0));
        // dma error wins over dma done, in the command phase already
        add_typed_row(start_word(6'd18, 1'b0, 32'h0000_1000, 16'h0, RT_R1, DIR_WRITE, 8'd0),
                      issue_word(6'd18, 32'h0000_1000, KIND_SHORT, DIR_WRITE));
        add_typed_row(event_word(MODE_DMA, F_DMAERR | F_DMADONE, 6'd0, 32'h0),
                      done_word(RC_DMA, 32'h0));
        // command timeout of one tick: the first tick ends the command phase
        add_cfg_row(REG_COMMAND_TIMEOUT, 32'd1);
        add_typed_row(start_word(6'd1, 1'b0, 32'h1, 16'h0, RT_NONE, DIR_NONE, 8'd0),
                      issue_word(6'd1, 32'h1, KIND_NONE, DIR_NONE));
        add_typed_row(event_word(MODE_TICK, 9'h000, 6'd0, 32'h0),
                      done_word(RC_SYSTIMEOUT, 32'h0));
        // card status error overrides the index mismatch
        add_typed_row(start_word(6'd40, 1'b0, 32'h0, 16'h0, RT_R1, DIR_NONE, 8'd0),
                      issue_word(6'd40, 32'h0, KIND_SHORT, DIR_NONE));
        add_typed_row(event_word(MODE_STATUS, F_REND, 6'd41, 32'h0000_0008),
                      done_word(RC_CARDSTATUS, 32'h0000_0008));

        // reset held low at the start of the run, once
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
            begin
                settle();
                write_register(directed_plan[i].reg_index, directed_plan[i].value);
            end
            else
            begin
                deliver(directed_plan[i].w, directed_plan[i].typed, directed_plan[i].res, acted);
                pace(1'b0);
            end
        end
        settle();

        // bottom of every range: no card status bit counts, ticks run out at once
        write_all(32'h0000_0000, 32'd1, 32'd1, 32'd1);
        run_phase(200);

        // top of every range
        write_all(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
        run_phase(200);

        // random masks and short timeouts, junk in the unused upper bits
        for (int p = 0; p < 4; p++)
        begin
            write_all($urandom,
                      {8'($urandom), 24'($urandom_range(1, 16))},
                      {8'($urandom), 24'($urandom_range(1, 16))},
                      {8'($urandom), 24'($urandom_range(1, 16))});
            if (p == 1) hold_off_request = 1'b1;
            run_phase(200);
        end

        if (mismatch_count == 0)
            $display("sd_host_command_sequencer_core test passed");
        else
            $display("sd_host_command_sequencer_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
